/* sv/utf8v_pkg.sv */
// utf8v_pkg: shared types and constants of the utf-8 text validator
// used by utf8v_out_if, utf8v_step, utf8_text_validator_core and tb; no dependencies

package utf8v_pkg;

  // default width of the length limit; the byte count is one bit wider
  localparam int LENGTH_BITS_DEFAULT = 16;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EMPTY_OK   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LENGTH = 2'd1;

  // code point width and byte codes
  localparam int CP_BITS = 21;
  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;

  // lead and continuation masks and patterns
  localparam logic [7:0] MASK_2B = 8'hE0;
  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] MASK_3B = 8'hF0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] MASK_4B = 8'hF8;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] MASK_CONT = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // code point limits
  localparam logic [CP_BITS-1:0] CP_MIN_3B     = 21'h000800;
  localparam logic [CP_BITS-1:0] CP_MIN_4B     = 21'h010000;
  localparam logic [CP_BITS-1:0] CP_SURR_LO    = 21'h00D800;
  localparam logic [CP_BITS-1:0] CP_SURR_HI    = 21'h00DFFF;
  localparam logic [CP_BITS-1:0] CP_MAX        = 21'h10FFFF;

  // sequence lengths
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_2B   = 3'd2;
  localparam logic [2:0] SEQ_3B   = 3'd3;
  localparam logic [2:0] SEQ_4B   = 3'd4;

  // decoder state of one string, apart from the byte count
  typedef struct packed {
    logic [1:0]         pending;
    logic [2:0]         seq_len;
    logic [CP_BITS-1:0] acc;
    logic               failed;
  } utf8v_state_t;

endpackage

/* sv/utf8v_in_if.sv */
// utf8v_in_if: byte channel into the validator, valid/ready handshake
// depends on nothing but the handshake convention of the project

interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

/* sv/utf8v_out_if.sv */
// utf8v_out_if: verdict channel out of the validator, valid/ready handshake
// byte_count width follows LENGTH_BITS; default width from utf8v_pkg

interface utf8v_out_if #(
  parameter int LENGTH_BITS = utf8v_pkg::LENGTH_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [LENGTH_BITS:0] byte_count;

  modport source (output valid, output accepted, output byte_count, input ready);
  modport sink   (input valid, input accepted, input byte_count, output ready);
endinterface

/* sv/utf8v_step.sv */
// utf8v_step: next decoder state and verdict for one word
// depends on utf8v_pkg

module utf8v_step #(
  parameter int LENGTH_BITS = utf8v_pkg::LENGTH_BITS_DEFAULT
) (
  input  utf8v_pkg::utf8v_state_t state,
  input  logic [LENGTH_BITS:0]    count,
  input  logic [7:0]              data_byte,
  input  logic                    has_byte,
  input  logic                    last,
  input  logic                    empty_ok,
  input  logic [LENGTH_BITS-1:0]  max_length,
  output utf8v_pkg::utf8v_state_t state_next,
  output logic [LENGTH_BITS:0]    count_next,
  output logic                    accepted,
  output logic [LENGTH_BITS:0]    byte_count
);

  utf8v_pkg::utf8v_state_t upd;
  logic [LENGTH_BITS:0]    cnt_upd;

  // saturating byte count: the top bit set means the count is at 2^LENGTH_BITS
  always_comb begin
    cnt_upd = count;
    if (has_byte && !count[LENGTH_BITS]) begin
      cnt_upd = count + {{LENGTH_BITS{1'b0}}, 1'b1};
    end
  end

  // lead or continuation byte
  always_comb begin
    logic                          bad_ctrl;
    logic [utf8v_pkg::CP_BITS-1:0] cp;
    logic [1:0]                    pend_dec;
    upd      = state;
    bad_ctrl = (data_byte == utf8v_pkg::BYTE_NUL) || (data_byte == utf8v_pkg::BYTE_DEL) ||
               ((data_byte < utf8v_pkg::BYTE_SPACE) && (data_byte != utf8v_pkg::BYTE_TAB) &&
                (data_byte != utf8v_pkg::BYTE_LF) && (data_byte != utf8v_pkg::BYTE_CR));
    cp       = {state.acc[utf8v_pkg::CP_BITS-7:0], data_byte[5:0]};
    pend_dec = state.pending - 2'd1;
    if (has_byte && !state.failed) begin
      if (state.pending == 2'd0) begin
        // lead byte
        if (bad_ctrl) begin
          upd.failed = 1'b1;
        end else if (!data_byte[7]) begin
          upd = state;
        end else if ((data_byte & utf8v_pkg::MASK_2B) == utf8v_pkg::LEAD_2B) begin
          // c0 and c1 leads are always overlong
          if (data_byte[4:1] == 4'd0) begin
            upd.failed = 1'b1;
          end else begin
            upd.seq_len = utf8v_pkg::SEQ_2B;
            upd.pending = 2'd1;
            upd.acc     = {{(utf8v_pkg::CP_BITS-5){1'b0}}, data_byte[4:0]};
          end
        end else if ((data_byte & utf8v_pkg::MASK_3B) == utf8v_pkg::LEAD_3B) begin
          upd.seq_len = utf8v_pkg::SEQ_3B;
          upd.pending = 2'd2;
          upd.acc     = {{(utf8v_pkg::CP_BITS-4){1'b0}}, data_byte[3:0]};
        end else if ((data_byte & utf8v_pkg::MASK_4B) == utf8v_pkg::LEAD_4B) begin
          upd.seq_len = utf8v_pkg::SEQ_4B;
          upd.pending = 2'd3;
          upd.acc     = {{(utf8v_pkg::CP_BITS-3){1'b0}}, data_byte[2:0]};
        end else begin
          upd.failed = 1'b1;
        end
      end else begin
        // continuation byte
        if ((data_byte & utf8v_pkg::MASK_CONT) != utf8v_pkg::CONT_TAG) begin
          upd.failed = 1'b1;
        end else if (pend_dec != 2'd0) begin
          upd.acc     = cp;
          upd.pending = pend_dec;
        end else begin
          // sequence complete: overlong, surrogate and range checks
          if (((state.seq_len == utf8v_pkg::SEQ_3B) && (cp < utf8v_pkg::CP_MIN_3B)) ||
              ((state.seq_len == utf8v_pkg::SEQ_4B) && (cp < utf8v_pkg::CP_MIN_4B)) ||
              ((cp >= utf8v_pkg::CP_SURR_LO) && (cp <= utf8v_pkg::CP_SURR_HI)) ||
              (cp > utf8v_pkg::CP_MAX)) begin
            upd.failed = 1'b1;
          end
          upd.pending = 2'd0;
          upd.seq_len = utf8v_pkg::SEQ_NONE;
          upd.acc     = '0;
        end
      end
    end
  end

  // verdict at end of string, then clear for the next one
  always_comb begin
    accepted   = !upd.failed && (upd.pending == 2'd0) &&
                 (cnt_upd <= {1'b0, max_length}) &&
                 ((cnt_upd != '0) || empty_ok);
    byte_count = cnt_upd;
    if (last) begin
      state_next = '0;
      count_next = '0;
    end else begin
      state_next = upd;
      count_next = cnt_upd;
    end
  end

endmodule

/* sv/utf8_text_validator_core.sv */
// utf8_text_validator_core: top level of the utf-8 text validator
// depends on utf8v_pkg, utf8v_in_if, utf8v_out_if and utf8v_step

// Takes one word per cycle on text unless the input register stalls, each word
// carrying at most one byte of a string, and gives one verdict on the verdict
// channel for each word with last set. The next decoder state comes combinationally
// from utf8v_step; the word is held in the input register and its verdict is loaded
// into the result register when the word advances. The input register keeps
// accepting while a verdict waits, and stalls only when a second string end meets a
// verdict not yet taken. Configuration writes (empty_ok at index 0, max_length at
// index 1) belong between strings.

module utf8_text_validator_core #(
  parameter int LENGTH_BITS = utf8v_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  utf8v_in_if.sink                            text,
  utf8v_out_if.source                         verdict,
  input  logic                                cfg_we,
  input  logic [utf8v_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LENGTH_BITS-1:0]              cfg_wdata
);

  // configuration
  logic                   empty_ok;
  logic [LENGTH_BITS-1:0] max_length;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_has;
  logic       in_last;

  // string state
  utf8v_pkg::utf8v_state_t state, state_next;
  logic [LENGTH_BITS:0]    count, count_next;

  // result register
  logic                 out_valid;
  logic                 out_accepted;
  logic [LENGTH_BITS:0] out_count;

  logic                 res_accepted;
  logic [LENGTH_BITS:0] res_count;
  logic                 advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_ok   <= 1'b0;
      max_length <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        utf8v_pkg::CFG_EMPTY_OK:   empty_ok   <= cfg_wdata[0];
        utf8v_pkg::CFG_MAX_LENGTH: max_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the held word moves on unless it ends a string and the result slot is full and not being taken
  assign advance    = in_valid && (!in_last || !out_valid || verdict.ready);
  assign text.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      in_byte <= text.data_byte;
      in_has  <= text.has_byte;
      in_last <= text.last;
    end
  end

  utf8v_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .state       (state),
    .count       (count),
    .data_byte   (in_byte),
    .has_byte    (in_has),
    .last        (in_last),
    .empty_ok    (empty_ok),
    .max_length  (max_length),
    .state_next  (state_next),
    .count_next  (count_next),
    .accepted    (res_accepted),
    .byte_count  (res_count)
  );

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      count <= '0;
    end else if (advance) begin
      state <= state_next;
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_accepted <= res_accepted;
      out_count    <= res_count;
    end
  end

  assign verdict.valid      = out_valid;
  assign verdict.accepted   = out_accepted;
  assign verdict.byte_count = out_count;

endmodule

/* sim/tb.sv */
// tb: self-checking testbench of utf8_text_validator_core; predicts the verdict of each
// string from its own byte decoder and checks every verdict word in order
// depends on utf8v_pkg, utf8v_in_if, utf8v_out_if and the core RTL

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LB = utf8v_pkg::LENGTH_BITS_DEFAULT;
  localparam int CPB = utf8v_pkg::CP_BITS;
  localparam int IB = utf8v_pkg::CFG_INDEX_BITS;
  localparam logic [LB:0] COUNT_SAT = {1'b1, {LB{1'b0}}};
  localparam int RANDOM_WORDS = 800;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic        accepted;
    logic [LB:0] byte_count;
  } verdict_t;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [IB-1:0] cfg_index;
  logic [LB-1:0] cfg_wdata;

  utf8v_in_if                      text_ch();
  utf8v_out_if #(.LENGTH_BITS(LB)) verdict_ch();

  utf8_text_validator_core #(.LENGTH_BITS(LB)) DUT (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .verdict   (verdict_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // decoder state and register copies of the predictor
  utf8v_pkg::utf8v_state_t dec_st = '0;
  logic [LB:0]             byte_total = '0;
  logic                    empty_ok_q = 1'b0;
  logic [LB-1:0]           max_length_q = '1;

  verdict_t   expected_verdicts[$];
  logic [7:0] text_buf[$];
  int         mismatches = 0;
  int         words_sent = 0;
  bit         fast_tx = 1'b0;
  bit         rx_steady = 1'b0;
  int         rx_hold = 0;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  function void restart_string();
    dec_st = '0;
    byte_total = '0;
  endfunction

  // first byte of a sequence
  function void decode_lead(logic [7:0] b);
    if (b == utf8v_pkg::BYTE_NUL || b == utf8v_pkg::BYTE_DEL ||
        (b < utf8v_pkg::BYTE_SPACE && b != utf8v_pkg::BYTE_TAB &&
         b != utf8v_pkg::BYTE_LF && b != utf8v_pkg::BYTE_CR)) begin
      dec_st.failed = 1'b1;
    end else if (!b[7]) begin
      // plain ascii, nothing pending
    end else if ((b & utf8v_pkg::MASK_2B) == utf8v_pkg::LEAD_2B) begin
      if (b[4:1] == 4'd0) begin
        dec_st.failed = 1'b1;
      end else begin
        dec_st.seq_len = utf8v_pkg::SEQ_2B;
        dec_st.pending = 2'd1;
        dec_st.acc = CPB'(b[4:0]);
      end
    end else if ((b & utf8v_pkg::MASK_3B) == utf8v_pkg::LEAD_3B) begin
      dec_st.seq_len = utf8v_pkg::SEQ_3B;
      dec_st.pending = 2'd2;
      dec_st.acc = CPB'(b[3:0]);
    end else if ((b & utf8v_pkg::MASK_4B) == utf8v_pkg::LEAD_4B) begin
      dec_st.seq_len = utf8v_pkg::SEQ_4B;
      dec_st.pending = 2'd3;
      dec_st.acc = CPB'(b[2:0]);
    end else begin
      dec_st.failed = 1'b1;
    end
  endfunction

  // continuation byte; range checks once the sequence completes
  function void decode_cont(logic [7:0] b);
    logic [CPB-1:0] cp;
    if ((b & utf8v_pkg::MASK_CONT) != utf8v_pkg::CONT_TAG) begin
      dec_st.failed = 1'b1;
      return;
    end
    cp = {dec_st.acc[CPB-7:0], b[5:0]};
    dec_st.acc = cp;
    dec_st.pending = dec_st.pending - 2'd1;
    if (dec_st.pending == 2'd0) begin
      if ((dec_st.seq_len == utf8v_pkg::SEQ_3B && cp < utf8v_pkg::CP_MIN_3B) ||
          (dec_st.seq_len == utf8v_pkg::SEQ_4B && cp < utf8v_pkg::CP_MIN_4B) ||
          (cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI) ||
          cp > utf8v_pkg::CP_MAX) begin
        dec_st.failed = 1'b1;
      end
      dec_st.seq_len = utf8v_pkg::SEQ_NONE;
      dec_st.acc = '0;
    end
  endfunction

  // update on one accepted word, queue the verdict at string end
  function void predict_word(logic [7:0] b, logic has, logic last);
    verdict_t v;
    if (has) begin
      if (byte_total < COUNT_SAT) byte_total = byte_total + (LB+1)'(1);
      if (!dec_st.failed) begin
        if (dec_st.pending == 2'd0) decode_lead(b);
        else decode_cont(b);
      end
    end
    if (last) begin
      v.accepted = !dec_st.failed && dec_st.pending == 2'd0 &&
                   byte_total <= {1'b0, max_length_q} &&
                   (byte_total != '0 || empty_ok_q);
      v.byte_count = byte_total;
      expected_verdicts.push_back(v);
      restart_string();
    end
  endfunction

  function void report_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
  endfunction

  // one word on the text channel, prediction at the handshake
  task send_word(input logic [7:0] b, input logic has, input logic last);
    int gap;
    gap = fast_tx ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.data_byte <= b;
    text_ch.has_byte  <= has;
    text_ch.last      <= last;
    do @(posedge clk); while (!text_ch.ready);
    predict_word(b, has, last);
    if (has || last) words_sent++;
  endtask

  // drop valid, wait for every verdict, then let the pipeline settle
  task quiesce();
    text_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic [IB-1:0] idx, input logic [LB-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == utf8v_pkg::CFG_EMPTY_OK) empty_ok_q = value[0];
    else if (idx == utf8v_pkg::CFG_MAX_LENGTH) max_length_q = value;
  endtask

  // send text_buf as one string, ended on its last byte or by an end-only marker
  task send_text(input bit end_marker);
    for (int i = 0; i < text_buf.size(); i++) begin
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(text_buf[i], 1'b1, !end_marker && i == text_buf.size() - 1);
    end
    if (end_marker || text_buf.size() == 0) send_word(8'($urandom), 1'b0, 1'b1);
    text_buf.delete();
  endtask

  // encode a code point in n bytes, overlong if n is larger than needed
  function void put_cp(logic [CPB-1:0] cp, int n);
    case (n)
      1: text_buf.push_back({1'b0, cp[6:0]});
      2: begin
        text_buf.push_back(utf8v_pkg::LEAD_2B | {3'b000, cp[10:6]});
        text_buf.push_back(utf8v_pkg::CONT_TAG | {2'b00, cp[5:0]});
      end
      3: begin
        text_buf.push_back(utf8v_pkg::LEAD_3B | {4'b0000, cp[15:12]});
        text_buf.push_back(utf8v_pkg::CONT_TAG | {2'b00, cp[11:6]});
        text_buf.push_back(utf8v_pkg::CONT_TAG | {2'b00, cp[5:0]});
      end
      default: begin
        text_buf.push_back(utf8v_pkg::LEAD_4B | {5'b00000, cp[20:18]});
        text_buf.push_back(utf8v_pkg::CONT_TAG | {2'b00, cp[17:12]});
        text_buf.push_back(utf8v_pkg::CONT_TAG | {2'b00, cp[11:6]});
        text_buf.push_back(utf8v_pkg::CONT_TAG | {2'b00, cp[5:0]});
      end
    endcase
  endfunction

  // well-formed character of random length
  function void put_valid();
    logic [CPB-1:0] cp;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      case ($urandom_range(0, 2))
        0: text_buf.push_back(utf8v_pkg::BYTE_TAB);
        1: text_buf.push_back(utf8v_pkg::BYTE_LF);
        default: text_buf.push_back(utf8v_pkg::BYTE_CR);
      endcase
    end else if (k < 4) begin
      text_buf.push_back(8'($urandom_range(32, 126)));
    end else if (k < 6) begin
      put_cp(CPB'($urandom_range(32'h80, 32'h7FF)), 2);
    end else if (k < 8) begin
      cp = CPB'($urandom_range(32'h800, 32'hFFFF));
      if (cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI) cp = cp ^ 21'h002000;
      put_cp(cp, 3);
    end else begin
      put_cp(CPB'($urandom_range(32'h10000, 32'h10FFFF)), 4);
    end
  endfunction

  // one broken piece of text
  function void put_flaw();
    logic [7:0] b;
    int n;
    int k;
    case ($urandom_range(0, 6))
      0: text_buf.push_back(8'($urandom));
      1: begin
        // overlong form
        n = $urandom_range(2, 4);
        if (n == 2) put_cp(CPB'($urandom_range(0, 32'h7F)), n);
        else if (n == 3) put_cp(CPB'($urandom_range(0, 32'h7FF)), n);
        else put_cp(CPB'($urandom_range(0, 32'hFFFF)), n);
      end
      2: put_cp(CPB'($urandom_range(32'hD800, 32'hDFFF)), 3);
      3: put_cp(CPB'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
      4: begin
        // truncated sequence
        n = $urandom_range(2, 4);
        put_cp(CPB'($urandom_range(32'h80, 32'h10FFFF)), n);
        repeat ($urandom_range(1, n - 1)) void'(text_buf.pop_back());
      end
      5: begin
        b = 8'($urandom_range(0, 31));
        if ($urandom_range(0, 3) == 0) b = utf8v_pkg::BYTE_DEL;
        text_buf.push_back(b);
      end
      default: begin
        // continuation without the 10 tag
        n = $urandom_range(2, 4);
        put_cp(CPB'($urandom_range(32'h80, 32'h10FFFF)), n);
        b = 8'($urandom);
        if ((b & utf8v_pkg::MASK_CONT) == utf8v_pkg::CONT_TAG) b = b ^ 8'h40;
        k = $urandom_range(1, n - 1);
        text_buf[text_buf.size() - k] = b;
      end
    endcase
  endfunction

  // mostly well-formed strings, some with one flaw, some pure noise
  function void build_random_string();
    int mode;
    int nseq;
    int pos;
    text_buf.delete();
    mode = $urandom_range(0, 3);
    if (mode == 2) begin
      repeat ($urandom_range(1, 16)) text_buf.push_back(8'($urandom));
    end else begin
      nseq = $urandom_range(0, 10);
      pos = (mode == 1) ? $urandom_range(0, nseq) : -1;
      for (int i = 0; i <= nseq; i++) begin
        if (i == pos) put_flaw();
        if (i < nseq) put_valid();
      end
    end
  endfunction

  // verdict channel: random stalls, compare against the oldest prediction
  always @(posedge clk) begin
    verdict_t seen;
    verdict_t want;
    if (rst) begin
      verdict_ch.ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        seen.accepted = verdict_ch.accepted;
        seen.byte_count = verdict_ch.byte_count;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with none pending, byte_count", -1, seen.byte_count);
        end else begin
          want = expected_verdicts.pop_front();
          if (seen.accepted !== want.accepted)
            report_mismatch("accepted", want.accepted, seen.accepted);
          if (seen.byte_count !== want.byte_count)
            report_mismatch("byte_count", want.byte_count, seen.byte_count);
        end
        if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
        rx_hold = rx_steady ? 0 : $urandom_range(0, 8);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      verdict_ch.ready <= (rx_hold == 0);
    end
  end

  // controls, truncation, bad leads, overlong, surrogate, range limit
  task test_directed_text();
    fast_tx = 1'b0;
    send_text(1'b1);
    send_word(utf8v_pkg::BYTE_TAB, 1'b1, 1'b0);
    send_word(utf8v_pkg::BYTE_LF, 1'b1, 1'b0);
    send_word(8'($urandom), 1'b0, 1'b0);
    send_word(utf8v_pkg::BYTE_CR, 1'b1, 1'b0);
    send_word(8'($urandom), 1'b0, 1'b1);
    text_buf = {utf8v_pkg::BYTE_NUL};
    send_text(1'b0);
    text_buf = {8'h41, utf8v_pkg::BYTE_DEL};
    send_text(1'b0);
    text_buf = {8'hC2};
    send_text(1'b0);
    text_buf = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text(1'b0);
    text_buf = {8'hF4, 8'h90, 8'h80, 8'h80};
    send_text(1'b0);
    text_buf = {8'hED, 8'hA0, 8'h80};
    send_text(1'b0);
    text_buf = {8'hE0, 8'h9F, 8'hBF};
    send_text(1'b0);
    text_buf = {8'hC1, 8'hBF};
    send_text(1'b0);
    text_buf = {8'h80};
    send_text(1'b0);
    text_buf = {8'hFF};
    send_text(1'b0);
    quiesce();
  endtask

  // empty strings and length limits at their extremes
  task test_config_extremes();
    logic [LB-1:0] v;
    v = LB'($urandom);
    v[0] = 1'b1;
    write_reg(utf8v_pkg::CFG_EMPTY_OK, v);
    send_text(1'b1);
    quiesce();
    write_reg(utf8v_pkg::CFG_MAX_LENGTH, '0);
    send_text(1'b1);
    text_buf = {8'h61};
    send_text(1'b0);
    quiesce();
    v = LB'($urandom);
    v[0] = 1'b0;
    write_reg(utf8v_pkg::CFG_EMPTY_OK, v);
    send_text(1'b1);
    quiesce();
    write_reg(utf8v_pkg::CFG_MAX_LENGTH, LB'(3));
    text_buf = {8'h61, 8'h62, 8'h63};
    send_text(1'b0);
    text_buf = {8'h61, 8'h62, 8'h63, 8'h64};
    send_text(1'($urandom_range(0, 1)));
    quiesce();
  endtask

  // random strings over several register settings
  task test_random_text();
    logic [LB-1:0] v;
    logic [LB-1:0] lim;
    int stop;
    for (int phase = 0; phase < 4; phase++) begin
      quiesce();
      v = LB'($urandom);
      case (phase)
        0: begin
          v[0] = 1'b1;
          lim = '1;
        end
        1: begin
          v[0] = 1'b0;
          lim = LB'($urandom_range(0, 24));
        end
        2: lim = LB'($urandom_range(8, 60));
        default: lim = LB'($urandom);
      endcase
      write_reg(utf8v_pkg::CFG_EMPTY_OK, v);
      write_reg(utf8v_pkg::CFG_MAX_LENGTH, lim);
      stop = words_sent + RANDOM_WORDS / 4;
      while (words_sent < stop) begin
        fast_tx = ($urandom_range(0, 3) == 0);
        build_random_string();
        send_text($urandom_range(0, 3) == 0);
        // hold the text side until all verdicts are out
        if ($urandom_range(0, 30) == 0) quiesce();
      end
    end
    fast_tx = 1'b0;
    quiesce();
  endtask

  // stimulus sequence
  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    text_ch.valid     <= 1'b0;
    text_ch.data_byte <= '0;
    text_ch.has_byte  <= 1'b0;
    text_ch.last      <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_text();
    test_config_extremes();
    test_random_text();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/utf8v_pkg.sv
sv/utf8v_in_if.sv
sv/utf8v_out_if.sv
sv/utf8v_step.sv
sv/utf8_text_validator_core.sv
sim/tb.sv
